[hw/rtl/lts_pkg.sv]
// ---------------------------------------------------------------------------
// lts_pkg
// Types and codes shared by the triangular solver files.
// ---------------------------------------------------------------------------
`default_nettype none
package lts_pkg;
    typedef enum logic [2:0] {
        REQ_LOWER = 3'd0,
        REQ_UPPER = 3'd1,
        REQ_PERM  = 3'd2,
        REQ_RHS   = 3'd3,
        REQ_SOLVE = 3'd4
    } req_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FWD_RD,
        ST_FWD_MAC,
        ST_FWD_WR,
        ST_BK_RD,
        ST_BK_MAC,
        ST_BK_DIV,
        ST_BK_WR,
        ST_OUT_RD,
        ST_OUT
    } state_t;

    // Input transfer: load or solve request
    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
        logic [3:0]  perm_source;
    } in_item_t;

    // Output transfer: one solution element
    typedef struct packed {
        logic [3:0]  index;
        logic [31:0] solution;
        logic        zero_pivot;
        logic        last;
    } out_item_t;
endpackage
`default_nettype wire

[hw/rtl/lts_if.sv]
// ---------------------------------------------------------------------------
// lts_if
// Valid/ready channel carrying one payload of parameter type.
// ---------------------------------------------------------------------------
`default_nettype none
interface lts_if #(parameter type payload_t = logic) ();
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/lu_triangular_solver.sv]
// ---------------------------------------------------------------------------
// lu_triangular_solver
// Permuted forward and back substitution on a stored LU factorization, Q16.16.
// ---------------------------------------------------------------------------
// channel | dir | payload
// in      | in  | req_type, row, col, value, perm_source
// out     | out | index, solution, zero_pivot, last
//
// Load items are written on their accept edge. A solve consists of one memory
// read and one multiply-accumulate per inner step, one write-back per row, a
// 48-step restoring divider per back substitution row, then DIM output
// transfers. Input is not taken while a solve runs. Output stalls hold the
// sequencer. Reset clears control only; stores are undefined until written.
`default_nettype none
module lu_triangular_solver #(
    parameter int DIM = 9
) (
    input wire logic clk,
    input wire logic rst_n,
    lts_if.sink      in_ch,
    lts_if.source    out_ch
);
    import lts_pkg::*;

    localparam int AW = $clog2(DIM * DIM);
    localparam int IW = $clog2(DIM + 1);

    // Stores
    logic [31:0] low_mem [DIM*DIM];
    logic [31:0] up_mem  [DIM*DIM];
    logic [31:0] vec_mem [3*DIM];     // rhs, work, solution
    logic [3:0]  perm_mem [DIM];

    logic [31:0] low_rd_reg, up_rd_reg, vec_rd_reg, vec2_rd_reg;

    state_t state_reg, state_next;
    logic [IW-1:0] i_reg, j_reg;
    logic [31:0] acc_reg, diag_reg;
    logic        zp_reg;
    logic [5:0]  dcnt_reg;
    logic [63:0] rem_reg;
    logic [47:0] quo_reg;
    logic        neg_reg;
    logic [31:0] res_reg;

    // Decode of input item
    logic [2:0]  in_req;
    logic [3:0]  in_row, in_col, in_ps;
    logic [31:0] in_val;
    assign in_req = in_ch.data.req_type;
    assign in_row = in_ch.data.row;
    assign in_col = in_ch.data.col;
    assign in_val = in_ch.data.value;
    assign in_ps  = in_ch.data.perm_source;

    logic in_xfer;
    assign in_ch.ready = (state_reg == ST_IDLE);
    assign in_xfer = in_ch.valid && in_ch.ready;

    logic row_ok, col_ok, ps_ok;
    assign row_ok = {28'd0, in_row} < 32'(DIM);
    assign col_ok = {28'd0, in_col} < 32'(DIM);
    assign ps_ok  = {28'd0, in_ps} < 32'(DIM);

    logic [AW-1:0] in_addr;
    assign in_addr = AW'({28'd0, in_row} * 32'(DIM) + {28'd0, in_col});

    // Read addresses from the sequencer
    logic [AW-1:0] low_ra, up_ra;
    logic [$clog2(3*DIM)-1:0] vec_ra, vec2_ra;
    logic [3:0] perm_i;
    assign perm_i = perm_mem[i_reg[$clog2(DIM)-1:0]];
    assign low_ra = AW'(32'(i_reg) * 32'(DIM) + 32'(j_reg));
    assign up_ra  = AW'(32'(i_reg) * 32'(DIM) + 32'(j_reg));

    always_comb
    begin
        vec_ra  = '0;
        vec2_ra = '0;
        unique case (state_reg)
            ST_FWD_RD: begin
                vec_ra  = $bits(vec_ra)'(32'(j_reg) + 32'(DIM));
                vec2_ra = $bits(vec2_ra)'(perm_i);
            end
            ST_BK_RD: begin
                vec_ra  = $bits(vec_ra)'(32'(j_reg) + 32'(2 * DIM));
                vec2_ra = $bits(vec2_ra)'(32'(i_reg) + 32'(DIM));
            end
            // keep reading the same element while the output waits
            ST_OUT_RD, ST_OUT: vec_ra = $bits(vec_ra)'(32'(i_reg) + 32'(2 * DIM));
            default: ;
        endcase
    end

    // Memory writes from loads and from the sequencer
    logic        vwe;
    logic [$clog2(3*DIM)-1:0] vwa;
    assign vwe = (state_reg == ST_FWD_WR) || (state_reg == ST_BK_WR)
              || (in_xfer && in_req == REQ_RHS && row_ok);
    always_comb
    begin
        if (state_reg == ST_FWD_WR)
            vwa = $bits(vwa)'(32'(i_reg) + 32'(DIM));
        else if (state_reg == ST_BK_WR)
            vwa = $bits(vwa)'(32'(i_reg) + 32'(2 * DIM));
        else
            vwa = $bits(vwa)'(in_row);
    end
    logic [31:0] vwd;
    assign vwd = (state_reg == ST_FWD_WR) ? acc_reg
               : (state_reg == ST_BK_WR) ? res_reg : in_val;

    always_ff @(posedge clk)
    begin
        if (in_xfer && in_req == REQ_LOWER && row_ok && col_ok)
            low_mem[in_addr] <= in_val;
        low_rd_reg <= low_mem[low_ra];
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && in_req == REQ_UPPER && row_ok && col_ok)
            up_mem[in_addr] <= in_val;
        up_rd_reg <= up_mem[up_ra];
    end

    always_ff @(posedge clk)
    begin
        if (vwe)
            vec_mem[vwa] <= vwd;
        vec_rd_reg  <= vec_mem[vec_ra];
        vec2_rd_reg <= vec_mem[vec2_ra];
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && in_req == REQ_PERM && row_ok && ps_ok)
            perm_mem[in_row[$clog2(DIM)-1:0]] <= in_ps;
    end

    // Product floored to Q16.16
    logic signed [63:0] prod;
    assign prod = (state_reg == ST_FWD_MAC)
                ? $signed(low_rd_reg) * $signed(vec_rd_reg)
                : $signed(up_rd_reg) * $signed(vec_rd_reg);

    // Sequencer
    logic out_xfer;
    assign out_xfer = out_ch.valid && out_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (in_xfer && in_req == REQ_SOLVE) state_next = ST_FWD_RD;
            ST_FWD_RD:  state_next = ST_FWD_MAC;
            ST_FWD_MAC: state_next = (j_reg >= i_reg) ? ST_FWD_WR : ST_FWD_RD;
            ST_FWD_WR:  state_next = (i_reg == IW'(DIM - 1)) ? ST_BK_RD : ST_FWD_RD;
            ST_BK_RD:   state_next = ST_BK_MAC;
            ST_BK_MAC:  state_next = (j_reg == IW'(DIM - 1)) ? ST_BK_DIV : ST_BK_RD;
            ST_BK_DIV:  state_next = (dcnt_reg == 6'd49) ? ST_BK_WR : ST_BK_DIV;
            ST_BK_WR:   state_next = (i_reg == '0) ? ST_OUT_RD : ST_BK_RD;
            ST_OUT_RD:  state_next = ST_OUT;
            ST_OUT:     if (out_ch.ready)
                            state_next = (i_reg == IW'(DIM - 1)) ? ST_IDLE : ST_OUT_RD;
            default:    state_next = ST_IDLE;
        endcase
    end

    // Datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg <= '0;
            j_reg <= '0;
            zp_reg <= 1'b0;
            dcnt_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                    if (in_xfer && in_req == REQ_SOLVE)
                    begin
                        i_reg <= '0;
                        j_reg <= '0;
                        zp_reg <= 1'b0;
                    end
                ST_FWD_MAC:
                    if (j_reg < i_reg)
                        j_reg <= j_reg + 1'b1;
                ST_FWD_WR:
                begin
                    if (i_reg == IW'(DIM - 1))
                        j_reg <= IW'(DIM - 1);
                    else
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + 1'b1;
                    end
                end
                ST_BK_MAC:
                begin
                    dcnt_reg <= '0;
                    if (j_reg != IW'(DIM - 1))
                        j_reg <= j_reg + 1'b1;
                end
                ST_BK_DIV:
                    dcnt_reg <= dcnt_reg + 1'b1;
                ST_BK_WR:
                begin
                    if (diag_reg == '0)
                        zp_reg <= 1'b1;
                    if (i_reg != '0)
                    begin
                        i_reg <= i_reg - 1'b1;
                        j_reg <= i_reg - 1'b1;
                    end
                end
                ST_OUT:
                    if (out_ch.ready && i_reg != IW'(DIM - 1))
                        i_reg <= i_reg + 1'b1;
                default: ;
            endcase
        end
    end

    // Accumulator and divider
    logic [31:0] an, ad;
    assign an = acc_reg[31] ? -acc_reg : acc_reg;
    assign ad = diag_reg[31] ? -diag_reg : diag_reg;
    logic [64:0] rem_sh;
    assign rem_sh = {rem_reg, quo_reg[47]};

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_FWD_MAC:
                if (j_reg == '0 && i_reg == '0)
                    acc_reg <= vec2_rd_reg;
                else if (j_reg == '0)
                    acc_reg <= vec2_rd_reg - 32'(prod >>> 16);
                else if (j_reg < i_reg)
                    acc_reg <= acc_reg - 32'(prod >>> 16);
            // first step of a row loads the work element and the diagonal
            ST_BK_MAC:
                if (j_reg == i_reg)
                begin
                    acc_reg  <= vec2_rd_reg;
                    diag_reg <= up_rd_reg;
                end
                else
                    acc_reg <= acc_reg - 32'(prod >>> 16);
            ST_BK_DIV:
                if (dcnt_reg == '0)
                begin
                    rem_reg <= '0;
                    quo_reg <= {an, 16'd0};
                    neg_reg <= acc_reg[31] ^ diag_reg[31];
                end
                else if (dcnt_reg <= 6'd48)
                begin
                    if (rem_sh[63:0] >= {32'd0, ad})
                    begin
                        rem_reg <= rem_sh[63:0] - {32'd0, ad};
                        quo_reg <= {quo_reg[46:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[63:0];
                        quo_reg <= {quo_reg[46:0], 1'b0};
                    end
                end
                else
                    res_reg <= (diag_reg == '0) ? '0
                             : (neg_reg ? -quo_reg[31:0] : quo_reg[31:0]);
            default: ;
        endcase
    end

    // Output
    assign out_ch.valid = (state_reg == ST_OUT);
    assign out_ch.data.index = 4'(i_reg);
    assign out_ch.data.solution = vec_rd_reg;
    assign out_ch.data.zero_pivot = zp_reg;
    assign out_ch.data.last = (i_reg == IW'(DIM - 1));

    // Checks
    a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ch.ready)
        else $error("input taken during solve");
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_xfer && out_ch.data.last) |=> (state_reg == ST_IDLE))
        else $error("run did not end after last");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> $stable(out_ch.data.solution))
        else $error("solution changed under stall");
endmodule
`default_nettype wire
